>>> src/battery_protection_fault_latch_assert.svh
// Assertion macros for the battery protection fault latch.
// Used by the top level; expects clk and rst in scope.
`ifndef BATTERY_PROTECTION_FAULT_LATCH_ASSERT_SVH
`define BATTERY_PROTECTION_FAULT_LATCH_ASSERT_SVH

// Checked only outside reset.
`define BPFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked in and out of reset.
`define BPFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bpfl_pkg.sv
// Package for the battery protection fault latch: payload, config and state
// types, command/status/fault codes and register reset values. No dependencies.
`default_nettype none

package bpfl_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_OVER_VOLTAGE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNDER_VOLTAGE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OVER_TEMP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BAD_TEMP      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SUB_TEMP      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COOLDOWN      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SOC_GAIN      = 3'd6;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_ACK    = 2'd1;
  localparam logic [1:0] FUNC_OPEN   = 2'd2;
  localparam logic [1:0] FUNC_CLOSE  = 2'd3;

  localparam logic [2:0] STATUS_NORMAL       = 3'd0;
  localparam logic [2:0] STATUS_SKIPPED      = 3'd1;
  localparam logic [2:0] STATUS_TRIPPED      = 3'd2;
  localparam logic [2:0] STATUS_ACK_OK       = 3'd3;
  localparam logic [2:0] STATUS_ACK_REJECT   = 3'd4;
  localparam logic [2:0] STATUS_OPENED       = 3'd5;
  localparam logic [2:0] STATUS_CLOSE_OK     = 3'd6;
  localparam logic [2:0] STATUS_CLOSE_REJECT = 3'd7;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_OVER_V  = 2'd1;
  localparam logic [1:0] FAULT_UNDER_V = 2'd2;
  localparam logic [1:0] FAULT_OVER_T  = 2'd3;

  localparam logic [6:0] SOC_MAX = 7'd100;

  localparam logic [13:0]        RST_OVER_VOLTAGE  = 14'd4200;
  localparam logic [13:0]        RST_UNDER_VOLTAGE = 14'd3000;
  localparam logic signed [11:0] RST_OVER_TEMP     = 12'sd450;
  localparam logic signed [11:0] RST_BAD_TEMP      = 12'sd1000;
  localparam logic signed [11:0] RST_SUB_TEMP      = 12'sd300;
  localparam logic [31:0]        RST_COOLDOWN      = 32'd30000;
  localparam logic [15:0]        RST_SOC_GAIN      = 16'd5461;

  typedef struct packed {
    logic [1:0]         func;
    logic [13:0]        voltage_mv;
    logic signed [11:0] temp_decideg;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic [2:0] status;
    logic       disconnected;
    logic [1:0] fault_kind;
    logic [6:0] soc_percent;
    logic       notify;
  } result_t;

  typedef struct packed {
    logic [13:0]        over_voltage_mv;
    logic [13:0]        under_voltage_mv;
    logic signed [11:0] over_temp_decideg;
    logic signed [11:0] bad_temp_decideg;
    logic signed [11:0] substitute_temp_decideg;
    logic [31:0]        notify_cooldown_ms;
    logic [15:0]        soc_gain;
  } cfg_t;

  typedef struct packed {
    logic        latched;
    logic [1:0]  stored_fault;
    logic [31:0] last_notify_ms;
  } state_t;

endpackage

`default_nettype wire

>>> src/battery_protection_fault_latch.sv
// Battery protection fault latch, top level: input register, decision
// logic, result register and latch state. Depends on bpfl_pkg, bpfl_regs,
// bpfl_eval and battery_protection_fault_latch_assert.svh.
//
// Usage:
//   sample channel (sample_valid/sample_ready/sample) carries one command or
//   reading per transfer; result channel (result_valid/result_ready/result)
//   returns exactly one result per accepted item, in order.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only while
//   no item is in flight.
// Flow: an accepted item is decided from the input register, and its result is
//   loaded into the result register once that register is empty or being taken.
// Throughput: one item per cycle while results are taken; the path between
//   the registers holds one 14x16 multiply plus the compares and the latch update.
// Reset: clears both pipeline valids, the latch, the stored fault and the
//   last notification time, and loads register defaults.
// Stall: while result_ready is low the result holds; the input register
//   still takes one more item, then sample_ready drops until the result is
//   transferred.
`default_nettype none

`include "battery_protection_fault_latch_assert.svh"

module battery_protection_fault_latch (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             sample_valid,
  output logic                                  sample_ready,
  input  wire bpfl_pkg::sample_t                sample,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output bpfl_pkg::result_t                     result,
  input  wire logic                             cfg_we,
  input  wire logic [bpfl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bpfl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bpfl_pkg::cfg_t    cfg;
  bpfl_pkg::state_t  state;
  bpfl_pkg::state_t  state_next;
  bpfl_pkg::sample_t item;
  bpfl_pkg::result_t res;
  logic              item_valid;
  logic              load;

  bpfl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpfl_eval u_eval (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .res        (res),
    .state_next (state_next)
  );

  assign load         = item_valid && (!result_valid || result_ready);
  assign sample_ready = !item_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample_ready) begin
      item_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      item <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.latched        <= 1'b0;
      state.stored_fault   <= bpfl_pkg::FAULT_NONE;
      state.last_notify_ms <= 32'd0;
    end else if (load) begin
      state <= state_next;
    end
  end

  `BPFL_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid && !item_valid, "valid after reset")
  `BPFL_ASSERT(a_relay_tracks_latch, result_valid |-> result.disconnected == state.latched, "relay mismatch")
  `BPFL_ASSERT(a_fault_tracks_state, result_valid |-> result.fault_kind == state.stored_fault, "fault mismatch")
  `BPFL_ASSERT(a_notify_on_trip, result_valid && result.notify |-> result.status == bpfl_pkg::STATUS_TRIPPED, "notify without trip")
  `BPFL_ASSERT(a_soc_range, result_valid |-> result.soc_percent <= bpfl_pkg::SOC_MAX, "soc above max")

endmodule

`default_nettype wire

>>> src/bpfl_regs.sv
// Configuration register file for the battery protection fault latch.
// Depends on bpfl_pkg.
`default_nettype none

module bpfl_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bpfl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [bpfl_pkg::CFG_DATA_W-1:0]      cfg_data,
  output bpfl_pkg::cfg_t                            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.over_voltage_mv         <= bpfl_pkg::RST_OVER_VOLTAGE;
      cfg.under_voltage_mv        <= bpfl_pkg::RST_UNDER_VOLTAGE;
      cfg.over_temp_decideg       <= bpfl_pkg::RST_OVER_TEMP;
      cfg.bad_temp_decideg        <= bpfl_pkg::RST_BAD_TEMP;
      cfg.substitute_temp_decideg <= bpfl_pkg::RST_SUB_TEMP;
      cfg.notify_cooldown_ms      <= bpfl_pkg::RST_COOLDOWN;
      cfg.soc_gain                <= bpfl_pkg::RST_SOC_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpfl_pkg::REG_OVER_VOLTAGE:  cfg.over_voltage_mv <= cfg_data[13:0];
        bpfl_pkg::REG_UNDER_VOLTAGE: cfg.under_voltage_mv <= cfg_data[13:0];
        bpfl_pkg::REG_OVER_TEMP:     cfg.over_temp_decideg <= $signed(cfg_data[11:0]);
        bpfl_pkg::REG_BAD_TEMP:      cfg.bad_temp_decideg <= $signed(cfg_data[11:0]);
        bpfl_pkg::REG_SUB_TEMP:      cfg.substitute_temp_decideg <= $signed(cfg_data[11:0]);
        bpfl_pkg::REG_COOLDOWN:      cfg.notify_cooldown_ms <= cfg_data;
        bpfl_pkg::REG_SOC_GAIN:      cfg.soc_gain <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/bpfl_eval.sv
// Per-item decision logic: state of charge, trip check, cooldown and
// command handling. Purely combinational. Depends on bpfl_pkg.
`default_nettype none

module bpfl_eval (
  input  wire bpfl_pkg::sample_t item,
  input  wire bpfl_pkg::cfg_t    cfg,
  input  wire bpfl_pkg::state_t  state,
  output bpfl_pkg::result_t      res,
  output bpfl_pkg::state_t       state_next
);

  logic               bad_temp;
  logic               above_uv;
  logic [13:0]        diff;
  logic [29:0]        prod;
  logic [13:0]        soc_raw;
  logic [6:0]         soc;
  logic               over_v;
  logic               under_v;
  logic               over_t;
  logic [1:0]         kind;
  logic signed [11:0] temp_cmd;
  logic               unsafe_cmd;
  logic [31:0]        elapsed;
  logic               cool_ok;

  assign bad_temp = $signed(item.temp_decideg) > $signed(cfg.bad_temp_decideg);
  assign above_uv = item.voltage_mv > cfg.under_voltage_mv;
  assign diff     = item.voltage_mv - cfg.under_voltage_mv;
  assign prod     = 30'(diff) * 30'(cfg.soc_gain);
  assign soc_raw  = prod[29:16];
  assign soc      = !above_uv ? 7'd0 :
                    (soc_raw > {7'd0, bpfl_pkg::SOC_MAX}) ? bpfl_pkg::SOC_MAX : soc_raw[6:0];

  assign over_v  = item.voltage_mv > cfg.over_voltage_mv;
  assign under_v = item.voltage_mv < cfg.under_voltage_mv;
  assign over_t  = $signed(item.temp_decideg) > $signed(cfg.over_temp_decideg);

  assign kind = over_v  ? bpfl_pkg::FAULT_OVER_V  :
                under_v ? bpfl_pkg::FAULT_UNDER_V :
                over_t  ? bpfl_pkg::FAULT_OVER_T  : bpfl_pkg::FAULT_NONE;

  assign temp_cmd   = bad_temp ? cfg.substitute_temp_decideg : item.temp_decideg;
  assign unsafe_cmd = over_v || under_v ||
                      ($signed(temp_cmd) > $signed(cfg.over_temp_decideg));

  // Cooldown measured modulo 2^32.
  assign elapsed = item.now_ms - state.last_notify_ms;
  assign cool_ok = elapsed >= cfg.notify_cooldown_ms;

  always_comb begin
    state_next      = state;
    res.status      = bpfl_pkg::STATUS_NORMAL;
    res.soc_percent = 7'd0;
    res.notify      = 1'b0;
    unique case (item.func)
      bpfl_pkg::FUNC_SAMPLE: begin
        if (bad_temp) begin
          res.status = bpfl_pkg::STATUS_SKIPPED;
        end else begin
          res.soc_percent = soc;
          if (!state.latched && kind != bpfl_pkg::FAULT_NONE) begin
            state_next.latched      = 1'b1;
            state_next.stored_fault = kind;
            res.status              = bpfl_pkg::STATUS_TRIPPED;
            if (cool_ok) begin
              res.notify                = 1'b1;
              state_next.last_notify_ms = item.now_ms;
            end
          end
        end
      end
      bpfl_pkg::FUNC_ACK: begin
        if (unsafe_cmd) begin
          res.status = bpfl_pkg::STATUS_ACK_REJECT;
        end else begin
          state_next.latched      = 1'b0;
          state_next.stored_fault = bpfl_pkg::FAULT_NONE;
          res.status              = bpfl_pkg::STATUS_ACK_OK;
        end
      end
      bpfl_pkg::FUNC_OPEN: begin
        state_next.latched = 1'b1;
        res.status         = bpfl_pkg::STATUS_OPENED;
      end
      default: begin
        if (unsafe_cmd) begin
          res.status = bpfl_pkg::STATUS_CLOSE_REJECT;
        end else begin
          state_next.latched = 1'b0;
          res.status         = bpfl_pkg::STATUS_CLOSE_OK;
        end
      end
    endcase
    res.disconnected = state_next.latched;
    res.fault_kind   = state_next.stored_fault;
  end

endmodule

`default_nettype wire

>>> tb/tb_battery_protection_fault_latch.sv
// Testbench for battery_protection_fault_latch: directed and random traffic
// checked against an in-bench predictor of the latch. Depends on bpfl_pkg.
`timescale 1ns / 1ps

module tb_battery_protection_fault_latch;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                             clk;
  logic                             rst;
  logic                             sample_valid;
  logic                             sample_ready;
  bpfl_pkg::sample_t                sample;
  logic                             result_valid;
  logic                             result_ready;
  bpfl_pkg::result_t                result;
  logic                             cfg_we;
  logic [bpfl_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bpfl_pkg::CFG_DATA_W-1:0]  cfg_data;

  battery_protection_fault_latch dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predictor state and register shadow.
  bpfl_pkg::cfg_t    cfg_shadow;
  logic              latch_q;
  logic [1:0]        fault_q;
  logic [31:0]       last_notice_ms;

  bpfl_pkg::result_t expected_results[$];
  int                error_count = 0;
  int                hold_cycles = 0;
  bit                no_idle = 1'b0;
  logic [31:0]       clock_ms = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bpfl_pkg::result_t predict_protection(input bpfl_pkg::sample_t s);
    bpfl_pkg::result_t r;
    int                t;
    int                tc;
    logic [63:0]       scaled;
    logic [1:0]        kind;
    logic [31:0]       since;
    logic              unsafe;
    r = '0;
    r.status = bpfl_pkg::STATUS_NORMAL;
    t = $signed(s.temp_decideg);
    case (s.func)
      bpfl_pkg::FUNC_SAMPLE: begin
        if (t > $signed(cfg_shadow.bad_temp_decideg)) begin
          r.status = bpfl_pkg::STATUS_SKIPPED;
        end else begin
          if (s.voltage_mv > cfg_shadow.under_voltage_mv) begin
            scaled = 64'(s.voltage_mv - cfg_shadow.under_voltage_mv);
            scaled = (scaled * 64'(cfg_shadow.soc_gain)) >> 16;
            r.soc_percent = (scaled > 64'(bpfl_pkg::SOC_MAX)) ?
                            bpfl_pkg::SOC_MAX : scaled[6:0];
          end
          if (!latch_q) begin
            kind = bpfl_pkg::FAULT_NONE;
            if (s.voltage_mv > cfg_shadow.over_voltage_mv)
              kind = bpfl_pkg::FAULT_OVER_V;
            else if (s.voltage_mv < cfg_shadow.under_voltage_mv)
              kind = bpfl_pkg::FAULT_UNDER_V;
            else if (t > $signed(cfg_shadow.over_temp_decideg))
              kind = bpfl_pkg::FAULT_OVER_T;
            if (kind != bpfl_pkg::FAULT_NONE) begin
              latch_q = 1'b1;
              fault_q = kind;
              r.status = bpfl_pkg::STATUS_TRIPPED;
              since = s.now_ms - last_notice_ms;
              if (since >= cfg_shadow.notify_cooldown_ms) begin
                r.notify = 1'b1;
                last_notice_ms = s.now_ms;
              end
            end
          end
        end
      end
      bpfl_pkg::FUNC_OPEN: begin
        latch_q = 1'b1;
        r.status = bpfl_pkg::STATUS_OPENED;
      end
      default: begin
        // bad reading is replaced by the substitute before the safety check
        tc = (t > $signed(cfg_shadow.bad_temp_decideg)) ?
             $signed(cfg_shadow.substitute_temp_decideg) : t;
        unsafe = (s.voltage_mv > cfg_shadow.over_voltage_mv) ||
                 (s.voltage_mv < cfg_shadow.under_voltage_mv) ||
                 (tc > $signed(cfg_shadow.over_temp_decideg));
        if (s.func == bpfl_pkg::FUNC_ACK) begin
          if (unsafe) begin
            r.status = bpfl_pkg::STATUS_ACK_REJECT;
          end else begin
            latch_q = 1'b0;
            fault_q = bpfl_pkg::FAULT_NONE;
            r.status = bpfl_pkg::STATUS_ACK_OK;
          end
        end else begin
          if (unsafe) begin
            r.status = bpfl_pkg::STATUS_CLOSE_REJECT;
          end else begin
            latch_q = 1'b0;
            r.status = bpfl_pkg::STATUS_CLOSE_OK;
          end
        end
      end
    endcase
    r.disconnected = latch_q;
    r.fault_kind = fault_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= 100)
      $display("%0t ERROR %s: got %0d expected %0d", $time, what, got, want);
  endtask

  // Called right after a posedge; returns right after the transfer edge.
  task automatic send_item(input bpfl_pkg::sample_t s);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!sample_ready);
    expected_results.push_back(predict_protection(s));
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpfl_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bpfl_pkg::CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  // Unused upper data bits carry junk; the block keeps only the register width.
  task automatic apply_config(input bpfl_pkg::cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(bpfl_pkg::REG_OVER_VOLTAGE, {junk[31:14], c.over_voltage_mv});
    write_reg(bpfl_pkg::REG_UNDER_VOLTAGE, {junk[31:14], c.under_voltage_mv});
    write_reg(bpfl_pkg::REG_OVER_TEMP, {junk[31:12], c.over_temp_decideg});
    write_reg(bpfl_pkg::REG_BAD_TEMP, {junk[31:12], c.bad_temp_decideg});
    write_reg(bpfl_pkg::REG_SUB_TEMP, {junk[31:12], c.substitute_temp_decideg});
    write_reg(bpfl_pkg::REG_COOLDOWN, c.notify_cooldown_ms);
    write_reg(bpfl_pkg::REG_SOC_GAIN, {junk[31:16], c.soc_gain});
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  function automatic bpfl_pkg::cfg_t rand_config();
    bpfl_pkg::cfg_t c;
    int             ot;
    c.under_voltage_mv = 14'($urandom_range(2500, 3400));
    c.over_voltage_mv = c.under_voltage_mv + 14'($urandom_range(200, 1500));
    ot = $urandom_range(0, 700);
    c.over_temp_decideg = 12'(ot);
    c.bad_temp_decideg = 12'(ot + $urandom_range(0, 800));
    c.substitute_temp_decideg = 12'(int'($urandom_range(0, 1100)) - 200);
    if ($urandom_range(0, 3) == 0) c.soc_gain = 16'($urandom);
    else c.soc_gain = 16'((100 * 65536) / (c.over_voltage_mv - c.under_voltage_mv));
    if ($urandom_range(0, 4) == 0) c.notify_cooldown_ms = $urandom;
    else c.notify_cooldown_ms = $urandom_range(0, 3000);
    return c;
  endfunction

  function automatic bpfl_pkg::sample_t make_item(input logic [1:0] f, input int v,
                                                  input int t, input logic [31:0] now);
    bpfl_pkg::sample_t s;
    s.func = f;
    s.voltage_mv = 14'(v);
    s.temp_decideg = 12'(t);
    s.now_ms = now;
    return s;
  endfunction

  // Mostly plausible readings near the thresholds, with some pure noise.
  task automatic send_random(input int count);
    bpfl_pkg::sample_t s;
    logic [63:0]       bits;
    int                pick;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        bits = {$urandom, $urandom};
        s = bits[$bits(bpfl_pkg::sample_t)-1:0];
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) s.func = bpfl_pkg::FUNC_SAMPLE;
        else if (pick < 75) s.func = bpfl_pkg::FUNC_ACK;
        else if (pick < 85) s.func = bpfl_pkg::FUNC_OPEN;
        else s.func = bpfl_pkg::FUNC_CLOSE;
        case ($urandom_range(0, 9))
          0: s.voltage_mv = cfg_shadow.under_voltage_mv - 14'd1;
          1: s.voltage_mv = cfg_shadow.under_voltage_mv;
          2: s.voltage_mv = cfg_shadow.over_voltage_mv;
          3: s.voltage_mv = cfg_shadow.over_voltage_mv + 14'd1;
          4: s.voltage_mv = 14'($urandom);
          default: s.voltage_mv = cfg_shadow.under_voltage_mv +
                                  14'($urandom_range(0, 1500));
        endcase
        case ($urandom_range(0, 9))
          0: s.temp_decideg = cfg_shadow.over_temp_decideg;
          1: s.temp_decideg = cfg_shadow.over_temp_decideg + 12'sd1;
          2: s.temp_decideg = cfg_shadow.bad_temp_decideg;
          3: s.temp_decideg = cfg_shadow.bad_temp_decideg + 12'sd1;
          4: s.temp_decideg = 12'($urandom);
          default: s.temp_decideg = cfg_shadow.over_temp_decideg -
                                    12'($urandom_range(0, 600));
        endcase
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + 32'($urandom_range(0, 800));
        s.now_ms = clock_ms;
      end
      send_item(s);
    end
  endtask

  task automatic test_directed_defaults();
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 3600, 250, 32'd1000));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 3600, 1001, 32'd1100));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 0, 2047, 32'd1200));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 4200, 450, 32'd2000));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 3000, -2048, 32'd2100));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 4201, 250, 32'd40000));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 16383, 250, 32'd41000));
    send_item(make_item(bpfl_pkg::FUNC_ACK, 5000, 250, 32'd42000));
    send_item(make_item(bpfl_pkg::FUNC_CLOSE, 3500, 460, 32'd43000));
    send_item(make_item(bpfl_pkg::FUNC_ACK, 3500, 2047, 32'd44000));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 2999, 0, 32'd50000));
    send_item(make_item(bpfl_pkg::FUNC_CLOSE, 3500, 250, 32'd51000));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 3500, 451, 32'd80000));
    send_item(make_item(bpfl_pkg::FUNC_OPEN, 0, -2048, 32'hFFFF_FFFF));
    send_item(make_item(bpfl_pkg::FUNC_ACK, 3500, 1000, 32'd81000));
    send_item(make_item(bpfl_pkg::FUNC_ACK, 3500, 250, 32'd82000));
    send_item(make_item(bpfl_pkg::FUNC_ACK, 3500, 250, 32'd83000));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 4201, 250, 32'h0000_1000));
    send_item(make_item(bpfl_pkg::FUNC_CLOSE, 2999, 250, 32'd0));
    send_item(make_item(bpfl_pkg::FUNC_CLOSE, 16383, -2048, 32'd0));
    send_item(make_item(bpfl_pkg::FUNC_ACK, 3500, 250, 32'd0));
    send_item(make_item(bpfl_pkg::FUNC_OPEN, 3500, 250, 32'd0));
    send_item(make_item(bpfl_pkg::FUNC_ACK, 3500, 250, 32'd0));
    send_item(make_item(bpfl_pkg::FUNC_SAMPLE, 0, 0, 32'hFFFF_FFFF));
    wait_idle();
  endtask

  task automatic test_config_extremes();
    bpfl_pkg::cfg_t c;
    c = '0;
    apply_config(c);
    send_random(30);
    wait_idle();
    c.over_voltage_mv = 14'h3FFF;
    c.under_voltage_mv = 14'h0000;
    c.over_temp_decideg = 12'sd2047;
    c.bad_temp_decideg = 12'sd2047;
    c.substitute_temp_decideg = -12'sd2048;
    c.notify_cooldown_ms = 32'hFFFF_FFFF;
    c.soc_gain = 16'hFFFF;
    apply_config(c);
    send_random(30);
    wait_idle();
    c.over_voltage_mv = 14'h0000;
    c.under_voltage_mv = 14'h3FFF;
    c.over_temp_decideg = -12'sd2048;
    c.bad_temp_decideg = -12'sd2048;
    c.substitute_temp_decideg = 12'sd2047;
    c.notify_cooldown_ms = 32'd0;
    c.soc_gain = 16'd0;
    apply_config(c);
    send_random(30);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    repeat (8) begin
      apply_config(rand_config());
      send_random(110);
      wait_idle();
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    send_random(100);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cycles = HOLD_OFF_CYCLES;
    send_random(30);
    wait_idle();
  endtask

  always @(posedge clk) begin : check_results
    bpfl_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", result.status, -1);
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
        if (result.disconnected !== want.disconnected)
          report_mismatch("disconnected", result.disconnected, want.disconnected);
        if (result.fault_kind !== want.fault_kind)
          report_mismatch("fault_kind", result.fault_kind, want.fault_kind);
        if (result.soc_percent !== want.soc_percent)
          report_mismatch("soc_percent", result.soc_percent, want.soc_percent);
        if (result.notify !== want.notify)
          report_mismatch("notify", result.notify, want.notify);
      end
    end
  end

  initial begin : result_sink
    int stall;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && sample_ready) || (result_valid && result_ready) || cfg_we || rst)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    cfg_shadow.over_voltage_mv = bpfl_pkg::RST_OVER_VOLTAGE;
    cfg_shadow.under_voltage_mv = bpfl_pkg::RST_UNDER_VOLTAGE;
    cfg_shadow.over_temp_decideg = bpfl_pkg::RST_OVER_TEMP;
    cfg_shadow.bad_temp_decideg = bpfl_pkg::RST_BAD_TEMP;
    cfg_shadow.substitute_temp_decideg = bpfl_pkg::RST_SUB_TEMP;
    cfg_shadow.notify_cooldown_ms = bpfl_pkg::RST_COOLDOWN;
    cfg_shadow.soc_gain = bpfl_pkg::RST_SOC_GAIN;
    latch_q = 1'b0;
    fault_q = bpfl_pkg::FAULT_NONE;
    last_notice_ms = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_config_extremes();
    test_random_traffic();
    test_back_to_back();
    test_backpressure();
    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
